[design/twewm_pkg.sv]
// Shared constants, types and helpers for the time-window equal-weight mean block.
// Depends on nothing; every other file in design/ but twewm_ram refers to it by scoped names.
`timescale 1ns / 1ps

package twewm_pkg;

    // Ring depth and the widths that follow from it
    localparam int WINDOW_DEPTH = 64;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int TIME_W       = 32;
    localparam int VALUE_W      = 32;
    localparam int SUM_W        = VALUE_W + $clog2(WINDOW_DEPTH);
    localparam int ENTRY_W      = TIME_W + VALUE_W;

    // Stream packing
    localparam int IN_TDATA_W   = TIME_W + VALUE_W;
    localparam int OUT_TDATA_W  = ((VALUE_W + CNT_W + 7) / 8) * 8;

    // Input queue between front and back
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_FILL_W     = $clog2(Q_DEPTH + 1);

    // Divider step counter
    localparam int STEP_W       = $clog2(SUM_W + 1);

    // One accepted sample
    typedef struct packed {
        logic                      restart;
        logic signed [VALUE_W-1:0] value;
        logic        [TIME_W-1:0]  stamp;
    } t_item;

    // Divider status toward the window engine
    typedef struct packed {
        logic                      busy;
        logic signed [VALUE_W-1:0] quotient;
    } t_div_status;

    // Advance a ring pointer with wrap at the ring depth
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

[design/twewm_ram.sv]
// Generic single-write, single-read memory with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module twewm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/twewm_front.sv]
// Input side: takes stream transfers, unpacks them into items and queues them.
// Depends on twewm_pkg.
`timescale 1ns / 1ps

module twewm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [twewm_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                                i_s_axis_tuser,
    output logic                                o_item_valid,
    input  logic                                i_item_ready,
    output twewm_pkg::t_item                    o_item
);

    twewm_pkg::t_item                     r_queue [twewm_pkg::Q_DEPTH];
    logic [twewm_pkg::Q_PTR_W-1:0]        r_wr_ptr;
    logic [twewm_pkg::Q_PTR_W-1:0]        r_rd_ptr;
    logic [twewm_pkg::Q_FILL_W-1:0]       r_fill;
    twewm_pkg::t_item                     in_item;
    logic                                 push;
    logic                                 pop;

    // Unpack: time in the low word, value above it, restart flag in tuser
    always_comb begin
        in_item.stamp   = i_s_axis_tdata[twewm_pkg::TIME_W-1:0];
        in_item.value   = i_s_axis_tdata[twewm_pkg::IN_TDATA_W-1:twewm_pkg::TIME_W];
        in_item.restart = i_s_axis_tuser;
    end

    assign o_s_axis_tready = (r_fill != twewm_pkg::Q_FILL_W'(twewm_pkg::Q_DEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_item_valid    = (r_fill != '0);
    assign pop             = o_item_valid && i_item_ready;
    assign o_item          = r_queue[r_rd_ptr];

    // Store incoming items
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == twewm_pkg::Q_PTR_W'(twewm_pkg::Q_DEPTH - 1)) ?
                            '0 : r_wr_ptr + twewm_pkg::Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == twewm_pkg::Q_PTR_W'(twewm_pkg::Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + twewm_pkg::Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + twewm_pkg::Q_FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - twewm_pkg::Q_FILL_W'(1);
            end
        end
    end

endmodule

[design/twewm_div.sv]
// Signed sum over unsigned count, truncated toward zero, one quotient bit per cycle.
// Depends on twewm_pkg.
`timescale 1ns / 1ps

module twewm_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [twewm_pkg::SUM_W-1:0]    i_dividend,
    input  logic        [twewm_pkg::CNT_W-1:0]    i_divisor,
    output twewm_pkg::t_div_status                o_status
);

    logic                             r_busy;
    logic [twewm_pkg::STEP_W-1:0]     r_step;
    logic [twewm_pkg::SUM_W-1:0]      r_quo;
    logic [twewm_pkg::CNT_W-1:0]      r_rem;
    logic [twewm_pkg::CNT_W-1:0]      r_div;
    logic                             r_neg;
    logic [twewm_pkg::CNT_W:0]        trial;
    logic                             fits;
    logic [twewm_pkg::SUM_W-1:0]      mag;
    logic [twewm_pkg::SUM_W-1:0]      signed_quo;

    assign mag   = i_dividend[twewm_pkg::SUM_W-1] ? -i_dividend : i_dividend;
    assign trial = {r_rem, r_quo[twewm_pkg::SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // Restore the sign on the magnitude quotient
    assign signed_quo        = r_neg ? -r_quo : r_quo;
    assign o_status.busy     = r_busy;
    assign o_status.quotient = signed_quo[twewm_pkg::VALUE_W-1:0];

    // Shift-subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[twewm_pkg::SUM_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? twewm_pkg::CNT_W'(trial - {1'b0, r_div})
                          : trial[twewm_pkg::CNT_W-1:0];
            r_quo <= {r_quo[twewm_pkg::SUM_W-2:0], fits};
        end
    end

    // Count the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= twewm_pkg::STEP_W'(twewm_pkg::SUM_W);
        end else if (r_busy) begin
            r_step <= r_step - twewm_pkg::STEP_W'(1);
            r_busy <= (r_step != twewm_pkg::STEP_W'(1));
        end
    end

endmodule

[design/twewm_back.sv]
// Window engine: expires old entries from the ring, inserts the sample,
// keeps the running sum and drives the result register.
// Depends on twewm_pkg, twewm_ram and twewm_div.
`timescale 1ns / 1ps

module twewm_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [twewm_pkg::TIME_W-1:0]          i_cfg_wr_data,
    input  logic                                  i_item_valid,
    output logic                                  o_item_ready,
    input  twewm_pkg::t_item                      i_item,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [twewm_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                  o_m_axis_tuser
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_CHECK  = 6'b000100,
        S_INSERT = 6'b001000,
        S_START  = 6'b010000,
        S_DIV    = 6'b100000
    } t_state;

    t_state                                   r_state;
    logic [twewm_pkg::TIME_W-1:0]             r_width;
    logic [twewm_pkg::PTR_W-1:0]              r_oldest;
    logic [twewm_pkg::PTR_W-1:0]              r_newest;
    logic [twewm_pkg::CNT_W-1:0]              r_count;
    logic signed [twewm_pkg::SUM_W-1:0]       r_sum;
    logic [twewm_pkg::TIME_W-1:0]             r_time;
    logic signed [twewm_pkg::VALUE_W-1:0]     r_value;
    logic                                     r_forced;
    logic                                     r_out_valid;
    logic signed [twewm_pkg::VALUE_W-1:0]     r_out_mean;
    logic [twewm_pkg::CNT_W-1:0]              r_out_count;
    logic                                     r_out_forced;

    logic [twewm_pkg::ENTRY_W-1:0]            rd_entry;
    logic [twewm_pkg::TIME_W-1:0]             old_time;
    logic signed [twewm_pkg::VALUE_W-1:0]     old_value;
    logic [twewm_pkg::TIME_W-1:0]             width_eff;
    logic [twewm_pkg::TIME_W:0]               old_limit;
    logic                                     expired;
    logic                                     ring_full;
    logic                                     wr_en;
    logic                                     div_start;
    twewm_pkg::t_div_status                   div_status;
    logic                                     out_free;
    logic                                     out_load;

    // Ring of (value, time) pairs, read at the oldest slot every cycle
    twewm_ram #(
        .WIDTH (twewm_pkg::ENTRY_W),
        .DEPTH (twewm_pkg::WINDOW_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_newest),
        .i_wr_data ({r_value, r_time}),
        .i_rd_addr (r_oldest),
        .o_rd_data (rd_entry)
    );

    twewm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_status   (div_status)
    );

    // Expiry test in one extra bit so the sum never wraps
    assign old_time  = rd_entry[twewm_pkg::TIME_W-1:0];
    assign old_value = rd_entry[twewm_pkg::ENTRY_W-1:twewm_pkg::TIME_W];
    assign width_eff = (r_width == '0) ? twewm_pkg::TIME_W'(1) : r_width;
    assign old_limit = {1'b0, old_time} + {1'b0, width_eff};
    assign expired   = (r_count != '0) && (old_limit <= {1'b0, r_time});
    assign ring_full = (r_count == twewm_pkg::CNT_W'(twewm_pkg::WINDOW_DEPTH));

    assign o_item_ready = (r_state == S_IDLE);
    assign wr_en        = (r_state == S_INSERT);
    assign div_start    = (r_state == S_START);
    assign out_free     = !r_out_valid || i_m_axis_tready;
    assign out_load     = (r_state == S_DIV) && !div_status.busy && out_free;

    // Window width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= twewm_pkg::TIME_W'(1);
        end else if (i_cfg_wr_en) begin
            r_width <= i_cfg_wr_data;
        end
    end

    // Latch the sample being worked on
    always_ff @(posedge i_clk) begin
        if (i_item_valid && o_item_ready) begin
            r_time  <= i_item.stamp;
            r_value <= i_item.value;
        end
    end

    // Sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_newest <= '0;
            r_count  <= '0;
            r_sum    <= '0;
            r_forced <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_forced <= 1'b0;
                        if (i_item.restart) begin
                            r_oldest <= '0;
                            r_newest <= '0;
                            r_count  <= '0;
                            r_sum    <= '0;
                        end
                        r_state <= S_FETCH;
                    end
                end
                // wait for the oldest entry to come out of the ring
                S_FETCH: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (expired || ring_full) begin
                        r_sum    <= r_sum - {{(twewm_pkg::SUM_W - twewm_pkg::VALUE_W)
                                              {old_value[twewm_pkg::VALUE_W-1]}}, old_value};
                        r_oldest <= twewm_pkg::next_slot(r_oldest);
                        r_count  <= r_count - twewm_pkg::CNT_W'(1);
                    end
                    if (expired) begin
                        r_state <= S_FETCH;
                    end else begin
                        r_forced <= ring_full;
                        r_state  <= S_INSERT;
                    end
                end
                S_INSERT: begin
                    r_sum    <= r_sum + {{(twewm_pkg::SUM_W - twewm_pkg::VALUE_W)
                                          {r_value[twewm_pkg::VALUE_W-1]}}, r_value};
                    r_newest <= twewm_pkg::next_slot(r_newest);
                    r_count  <= r_count + twewm_pkg::CNT_W'(1);
                    r_state  <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register: hold until the sink takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mean   <= div_status.quotient;
            r_out_count  <= r_count;
            r_out_forced <= r_forced;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = twewm_pkg::OUT_TDATA_W'({r_out_count, r_out_mean});
    assign o_m_axis_tuser  = r_out_forced;

endmodule

[design/time_window_equal_weight_mean.sv]
// Time-window equal-weight mean over timestamped Q16.16 samples. Each sample
// (time and value in tdata, restart flag in tuser) is queued on input, then
// the engine drops ring entries whose time plus window_width is at most the
// new time, evicts the oldest entry if all 64 slots still hold live samples
// (forced_eviction in tuser), inserts the sample and divides the running sum
// by the entry count, truncating toward zero. Each sample passes through accept,
// fetch, check, insert, divider start and result load, with one more fetch and
// check per expired entry, as the ring memory's read at the oldest slot is
// registered. The engine accepts no new sample until the restoring divider,
// which yields one quotient bit per cycle over the 38-bit sum, has finished and
// the result register has room for the result. A two-entry input queue and a
// result register let both stream sides stall on their own. A window_width of
// 0 acts as 1. No clearing pass follows reset.
// Depends on twewm_pkg, twewm_front and twewm_back.
`timescale 1ns / 1ps

module time_window_equal_weight_mean (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: window_width
    input  logic                                i_cfg_wr_en,
    input  logic [twewm_pkg::TIME_W-1:0]        i_cfg_wr_data,
    // sample stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [twewm_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // sample_time, sample_value
    input  logic                                i_s_axis_tuser,  // restart
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [twewm_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // mean_value, window_count
    output logic                                o_m_axis_tuser   // forced_eviction
);

    logic               item_valid;
    logic               item_ready;
    twewm_pkg::t_item   item;

    twewm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_item_valid    (item_valid),
        .i_item_ready    (item_ready),
        .o_item          (item)
    );

    twewm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_item_valid    (item_valid),
        .o_item_ready    (item_ready),
        .i_item          (item),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

[tb/tb_time_window_equal_weight_mean.sv]
// Self-checking testbench for time_window_equal_weight_mean: stream samples in, compare each
// result against an in-bench window predictor. Depends on twewm_pkg and the design top.
`timescale 1ns / 1ps

module tb_time_window_equal_weight_mean;

    localparam int TIME_W       = twewm_pkg::TIME_W;
    localparam int VALUE_W      = twewm_pkg::VALUE_W;
    localparam int CNT_W        = twewm_pkg::CNT_W;
    localparam int DEPTH        = twewm_pkg::WINDOW_DEPTH;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic signed [VALUE_W-1:0] mean;
        logic        [CNT_W-1:0]   count;
        logic                      forced;
    } mean_result_t;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_wr_en;
    logic [TIME_W-1:0]                  i_cfg_wr_data;
    logic                               i_s_axis_tvalid;
    logic                               o_s_axis_tready;
    logic [twewm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata;   // sample_time, sample_value
    logic                               i_s_axis_tuser;   // restart
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready;
    logic [twewm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;   // mean_value, window_count
    logic                               o_m_axis_tuser;   // forced_eviction

    time_window_equal_weight_mean dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Window predictor state
    logic [TIME_W-1:0]         slot_times  [DEPTH];
    logic signed [VALUE_W-1:0] slot_values [DEPTH];
    int                        oldest_slot;
    int                        newest_slot;
    logic [CNT_W-1:0]          live_count;
    longint                    window_sum;
    logic [TIME_W-1:0]         window_width_q;

    mean_result_t expected_means [$];

    int  mismatch_count;
    int  results_checked;
    int  samples_sent;
    int  restarts_sent;
    int  evictions_seen;
    int  width_settings;
    int  hold_requests;
    int  holds_served;
    int  idle_cycles;
    bit  tx_gaps_on;
    bit  rx_stalls_on;

    // Drop the oldest window entry from the predictor
    function automatic void drop_oldest_entry();
        window_sum  -= longint'(slot_values[oldest_slot]);
        oldest_slot  = (oldest_slot + 1) % DEPTH;
        live_count   = live_count - 1'b1;
    endfunction

    // Advance the predictor by one sample and return the result it causes
    function automatic mean_result_t predict_mean(input twewm_pkg::t_item s);
        logic [TIME_W:0] span;
        longint          quotient;
        mean_result_t    r;
        span = {1'b0, window_width_q};
        if (window_width_q == '0)
            span = (TIME_W+1)'(1);
        r.forced = 1'b0;
        if (s.restart) begin
            oldest_slot = 0;
            newest_slot = 0;
            live_count  = '0;
            window_sum  = 0;
        end
        // expire from the oldest end; the compare is one bit wider so it cannot wrap
        while (live_count > 0 && ({1'b0, slot_times[oldest_slot]} + span) <= {1'b0, s.stamp})
            drop_oldest_entry();
        if (live_count >= DEPTH) begin
            drop_oldest_entry();
            r.forced = 1'b1;
        end
        slot_times[newest_slot]  = s.stamp;
        slot_values[newest_slot] = s.value;
        newest_slot = (newest_slot + 1) % DEPTH;
        live_count  = live_count + 1'b1;
        window_sum += longint'(s.value);
        quotient = window_sum / longint'(live_count);
        r.mean  = quotient[VALUE_W-1:0];
        r.count = live_count;
        return r;
    endfunction

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        mean_result_t exp_r;
        mean_result_t got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.mean   = o_m_axis_tdata[VALUE_W-1:0];
            got.count  = o_m_axis_tdata[VALUE_W +: CNT_W];
            got.forced = o_m_axis_tuser;
            if (expected_means.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: mean %h count %0d evict %0b",
                             got.mean, got.count, got.forced);
            end else begin
                exp_r = expected_means.pop_front();
                if (got.forced)
                    evictions_seen++;
                if (got.mean !== exp_r.mean || got.count !== exp_r.count ||
                    got.forced !== exp_r.forced) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d: mean exp %h got %h, count exp %0d got %0d, evict exp %0b got %0b",
                                 results_checked, exp_r.mean, got.mean, exp_r.count,
                                 got.count, exp_r.forced, got.forced);
                end
            end
            results_checked++;
        end
    end

    // End the run if nothing transfers for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_means.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side ready: random stalls, plus long hold-offs on request
    initial begin
        int stall_len;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                stall_len = 400;
                i_m_axis_tready <= 1'b0;
                repeat (stall_len - 1) @(posedge i_clk);
            end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
                stall_len = ($urandom_range(0, 99) < 94) ? $urandom_range(1, 3)
                                                         : $urandom_range(15, 80);
                i_m_axis_tready <= 1'b0;
                repeat (stall_len - 1) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Hold off the sender for a random gap, mostly short
    task automatic insert_gap();
        int gap;
        int roll;
        gap = 0;
        if (tx_gaps_on) begin
            roll = $urandom_range(0, 99);
            if (roll >= 93)
                gap = $urandom_range(10, 50);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Offer one sample, wait for its transfer, then record the expected result
    task automatic send_sample(input logic [TIME_W-1:0] stamp, input logic [VALUE_W-1:0] value,
                               input logic restart);
        twewm_pkg::t_item s;
        s.stamp   = stamp;
        s.value   = value;
        s.restart = restart;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {s.value, s.stamp};
        i_s_axis_tuser  <= s.restart;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_means.push_back(predict_mean(s));
        samples_sent++;
        if (restart)
            restarts_sent++;
        insert_gap();
    endtask

    // Stop sending and wait until every result has arrived and the engine has settled
    task automatic wait_for_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_width(input logic [TIME_W-1:0] width);
        wait_for_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= width;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        window_width_q = width;
        width_settings++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    // Field extremes, wrap-free expiry near the top of time, zero width, time going back
    task automatic test_directed_edges();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_sample(32'd0,         32'h7FFF_FFFF, 1'b0);
        send_sample(32'd0,         32'h8000_0000, 1'b0);
        send_sample(32'd1,         32'hFFFF_FFFF, 1'b0);
        send_sample(32'd0,         32'h0001_0000, 1'b0);
        send_sample(32'd100,       32'h8000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        write_window_width(32'hFFFF_FFFF);
        send_sample(32'd0,         32'h1234_5678, 1'b1);
        send_sample(32'hFFFF_FFFE, 32'hEDCB_A987, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        write_window_width(32'd0);
        send_sample(32'd10,        32'hFFFF_0000, 1'b1);
        send_sample(32'd10,        32'h0001_8000, 1'b0);
        send_sample(32'd11,        32'h5555_5555, 1'b0);
        send_sample(32'd11,        32'hAAAA_AAAA, 1'b0);
        write_window_width(32'd5);
        send_sample(32'd20,        32'hFFFF_FFFD, 1'b1);
        send_sample(32'd22,        32'h0000_0001, 1'b0);
        send_sample(32'd24,        32'h0000_0001, 1'b0);
        send_sample(32'd25,        32'h0000_0000, 1'b0);
    endtask

    // Overfill the ring at the sum extremes, then expire a full ring in one step
    task automatic test_full_ring();
        logic [TIME_W-1:0] stamp;
        write_window_width(32'd1_000_000);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        stamp = $urandom_range(0, 32'h7FFF_FFFF);
        send_sample(stamp, 32'h7FFF_FFFF, 1'b1);
        repeat (DEPTH + 5) send_sample(stamp, 32'h7FFF_FFFF, 1'b0);
        send_sample(stamp, 32'h8000_0000, 1'b1);
        repeat (DEPTH + 5) begin
            stamp = stamp + $urandom_range(0, 3);
            send_sample(stamp, 32'h8000_0000, 1'b0);
        end
        stamp = stamp + 32'd1_000_000;
        send_sample(stamp, pick_value(), 1'b0);
        send_sample(stamp, pick_value(), 1'b0);
    endtask

    // Long receiver hold-off while samples keep coming, then a full drain
    task automatic test_backpressure();
        logic [TIME_W-1:0] stamp;
        write_window_width(32'd40);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        stamp = $urandom;
        hold_requests++;
        send_sample(stamp, pick_value(), 1'b1);
        repeat (30) begin
            stamp = stamp + $urandom_range(0, 4);
            send_sample(stamp, pick_value(), 1'b0);
        end
        wait_for_idle();
    endtask

    // Mostly non-decreasing series with random content, plus noise and broken sequences
    task automatic run_random_series(input int n_items);
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] w_eff;
        logic [TIME_W-1:0] span;
        int                roll;
        w_eff = (window_width_q == '0) ? 32'd1 : window_width_q;
        span  = (w_eff > 64) ? w_eff / 32 : 32'd1;
        stamp = $urandom;
        send_sample(stamp, pick_value(), 1'b1);
        repeat (n_items - 1) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                stamp = stamp + $urandom_range(0, span);
                send_sample(stamp, pick_value(), 1'b0);
            end else if (roll < 90) begin
                stamp = stamp + $urandom_range(0, w_eff) + $urandom_range(0, w_eff);
                send_sample(stamp, pick_value(), 1'b0);
            end else if (roll < 94) begin
                stamp = $urandom;
                send_sample(stamp, pick_value(), 1'b1);
            end else if (roll < 97) begin
                stamp = stamp - $urandom_range(1, span);
                send_sample(stamp, pick_value(), 1'b0);
            end else begin
                send_sample($urandom, $urandom, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Sweep window widths and idling modes over random series
    task automatic test_random_windows();
        logic [TIME_W-1:0] width;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       width = 32'd1;
                1:       width = 32'd0;
                2:       width = $urandom_range(2, 16);
                3:       width = $urandom_range(100, 1000);
                4:       width = 32'hFFFF_FFFF;
                6:       width = $urandom_range(20, 200);
                7:       width = 32'd1_000_000;
                8:       width = $urandom_range(1, 8);
                default: width = $urandom;
            endcase
            write_window_width(width);
            tx_gaps_on   = (phase % 3 != 0);
            rx_stalls_on = (phase % 4 != 0);
            run_random_series(PHASE_ITEMS);
        end
    endtask

    initial begin
        window_width_q  = 32'd1;
        oldest_slot     = 0;
        newest_slot     = 0;
        live_count      = '0;
        window_sum      = 0;
        mismatch_count  = 0;
        results_checked = 0;
        samples_sent    = 0;
        restarts_sent   = 0;
        evictions_seen  = 0;
        width_settings  = 1;
        hold_requests   = 0;
        holds_served    = 0;
        idle_cycles     = 0;
        tx_gaps_on      = 1'b0;
        rx_stalls_on    = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_full_ring();
        test_backpressure();
        test_random_windows();

        wait_for_idle();
        $display("run covered %0d samples (%0d restarts) over %0d window settings",
                 samples_sent, restarts_sent, width_settings);
        $display("checked %0d results, %0d with forced eviction, %0d receiver hold-offs",
                 results_checked, evictions_seen, holds_served);
        if (mismatch_count == 0 && expected_means.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
design/twewm_pkg.sv
design/twewm_ram.sv
design/twewm_front.sv
design/twewm_div.sv
design/twewm_back.sv
design/time_window_equal_weight_mean.sv
tb/tb_time_window_equal_weight_mean.sv
